/* rtl/scc_pkg.sv */
// Package for the strong connectivity check unit.
// Holds sizes, item and memory request types and the controller state enum.
// No dependencies.
package scc_pkg;

  localparam int MAX_V = 1024;
  localparam int MAX_E = 4096;
  localparam int VW    = 10;          // vertex index width
  localparam int EW    = 12;          // edge index width
  localparam int HW    = EW + 1;      // list link width, top bit marks end of list
  localparam int CNTW  = 11;          // vertex count / external vertex width
  localparam int ETW   = 13;          // stored edge total width

  localparam logic [HW-1:0]   NIL_LINK = {1'b1, {EW{1'b0}}};
  localparam logic [CNTW-1:0] NMAX     = CNTW'(MAX_V);
  localparam logic [ETW-1:0]  EMAX     = ETW'(MAX_E);

  localparam logic REQ_EDGE   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [CNTW-1:0] edge_from;
    logic [CNTW-1:0] edge_to;
  } in_item_t;

  typedef struct packed {
    logic            strongly_connected;
    logic [CNTW-1:0] component_count;
    logic            edges_dropped;
  } out_item_t;

  typedef struct packed {
    logic [VW-1:0] src;
    logic [VW-1:0] tgt;
    logic [HW-1:0] fnext;
    logic [HW-1:0] rnext;
  } edge_rec_t;

  typedef struct packed {
    logic [VW-1:0] vtx;
    logic [HW-1:0] link;
  } stk_rec_t;

  typedef struct packed {
    logic          we;
    logic [VW-1:0] waddr;
    logic [HW-1:0] wdata;
    logic [VW-1:0] raddr;
  } head_req_t;

  typedef struct packed {
    logic          we;
    logic [EW-1:0] waddr;
    edge_rec_t     wdata;
    logic [EW-1:0] raddr;
  } edge_req_t;

  typedef struct packed {
    logic          we;
    logic [VW-1:0] waddr;
    logic          wdata;
    logic [VW-1:0] raddr;
  } vis_req_t;

  typedef struct packed {
    logic          we;
    logic [VW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic [VW-1:0] raddr;
  } fin_req_t;

  typedef struct packed {
    logic          we;
    logic [VW-1:0] waddr;
    stk_rec_t      wdata;
    logic [VW-1:0] raddr;
  } stk_req_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EDGE_WR, S_P1_RD, S_P1_CHK, S_W_HEAD, S_W_EDGE,
    S_W_ERD, S_W_CHK, S_W_POP, S_VCLR, S_P2_RD, S_P2_VRD, S_P2_CHK, S_DONE
  } state_t;

endpackage

/* rtl/scc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/scc_ctrl.sv */
// Sequencer for the strong connectivity check: edge loading, both walk
// passes, clearing sweeps. Depends on scc_pkg; drives the memories in the top.
module scc_ctrl import scc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_item,
  output logic            out_valid,
  output out_item_t       out_item,
  input  logic [CNTW-1:0] vcount,
  output head_req_t       fh_req,
  input  logic [HW-1:0]   fh_rdata,
  output head_req_t       rh_req,
  input  logic [HW-1:0]   rh_rdata,
  output edge_req_t       ed_req,
  input  edge_rec_t       ed_rdata,
  output vis_req_t        vis_req,
  input  logic            vis_rdata,
  output fin_req_t        fin_req,
  input  logic [VW-1:0]   fin_rdata,
  output stk_req_t        stk_req,
  input  stk_rec_t        stk_rdata
);
  state_t state_r, state_nxt;

  logic [ETW-1:0]  etot_r, etot_nxt;
  logic            drop_r, drop_nxt;
  logic [VW-1:0]   sweep_r, sweep_nxt;
  logic [VW-1:0]   es_r, es_nxt, et_r, et_nxt;
  logic            pass_r, pass_nxt;
  logic [CNTW-1:0] v_r, v_nxt;
  logic [CNTW-1:0] fin_r, fin_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CNTW-1:0] d_r, d_nxt;
  logic [VW-1:0]   topv_r, topv_nxt;
  logic [HW-1:0]   tope_r, tope_nxt;
  logic [VW-1:0]   w_r, w_nxt;
  logic            ok_r, ok_nxt;

  logic [CNTW-1:0] n_eff, from_m1, to_m1, d_m1, d_m2, fin_m1, v_ext, w_ext;
  logic            edge_ok, push_ok, u_ok;
  logic [VW-1:0]   ew, eo;

  always_comb begin
    if (vcount == '0) begin
      n_eff = CNTW'(1);
    end else if (vcount > NMAX) begin
      n_eff = NMAX;
    end else begin
      n_eff = vcount;
    end
  end

  assign from_m1 = in_item.edge_from - CNTW'(1);
  assign to_m1   = in_item.edge_to - CNTW'(1);
  assign edge_ok = (in_item.edge_from != '0) && (in_item.edge_from <= n_eff) &&
                   (in_item.edge_to != '0) && (in_item.edge_to <= n_eff) &&
                   (etot_r < EMAX);
  assign d_m1    = d_r - CNTW'(1);
  assign d_m2    = d_r - CNTW'(2);
  assign fin_m1  = fin_r - CNTW'(1);
  assign v_ext   = v_r;
  assign w_ext   = {1'b0, w_r};
  assign push_ok = ok_r && !vis_rdata && (d_r < NMAX);
  assign u_ok    = ({1'b0, w_r} < n_eff) && !vis_rdata;
  assign ew      = pass_r ? ed_rdata.src : ed_rdata.tgt;
  assign eo      = pass_r ? ed_rdata.tgt : ed_rdata.src;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:     if (sweep_r == VW'(MAX_V - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (in_item.req_type == REQ_FINISH) begin
            state_nxt = S_P1_RD;
          end else if (edge_ok) begin
            state_nxt = S_EDGE_WR;
          end
        end
      end
      S_EDGE_WR: state_nxt = S_IDLE;
      S_P1_RD:   state_nxt = (v_r == n_eff) ? S_VCLR : S_P1_CHK;
      S_P1_CHK:  state_nxt = vis_rdata ? S_P1_RD : S_W_HEAD;
      S_W_HEAD:  state_nxt = S_W_EDGE;
      S_W_EDGE: begin
        if (!tope_r[HW-1]) begin
          state_nxt = S_W_ERD;
        end else if (d_r == CNTW'(1)) begin
          state_nxt = pass_r ? S_P2_RD : S_P1_RD;
        end else begin
          state_nxt = S_W_POP;
        end
      end
      S_W_POP:   state_nxt = S_W_EDGE;
      S_W_ERD:   state_nxt = S_W_CHK;
      S_W_CHK:   state_nxt = push_ok ? S_W_HEAD : S_W_EDGE;
      S_VCLR:    if (sweep_r == VW'(MAX_V - 1)) state_nxt = S_P2_RD;
      S_P2_RD:   state_nxt = (fin_r == '0) ? S_DONE : S_P2_VRD;
      S_P2_VRD:  state_nxt = S_P2_CHK;
      S_P2_CHK:  state_nxt = u_ok ? S_W_HEAD : S_P2_RD;
      S_DONE:    state_nxt = S_CLR;
      default:   state_nxt = S_CLR;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    etot_nxt = etot_r;  drop_nxt = drop_r;  sweep_nxt = sweep_r;
    es_nxt = es_r;  et_nxt = et_r;  pass_nxt = pass_r;  v_nxt = v_r;
    fin_nxt = fin_r;  cnt_nxt = cnt_r;  d_nxt = d_r;  topv_nxt = topv_r;
    tope_nxt = tope_r;  w_nxt = w_r;  ok_nxt = ok_r;
    fh_req = '0;  rh_req = '0;  ed_req = '0;  vis_req = '0;  fin_req = '0;
    stk_req = '0;
    busy = (state_r != S_IDLE);
    out_valid = 1'b0;
    out_item = '0;
    case (state_r)
      S_CLR: begin
        fh_req.we = 1'b1;  fh_req.waddr = sweep_r;  fh_req.wdata = NIL_LINK;
        rh_req.we = 1'b1;  rh_req.waddr = sweep_r;  rh_req.wdata = NIL_LINK;
        vis_req.we = 1'b1; vis_req.waddr = sweep_r; vis_req.wdata = 1'b0;
        sweep_nxt = sweep_r + VW'(1);
      end
      S_IDLE: begin
        fh_req.raddr = from_m1[VW-1:0];
        rh_req.raddr = to_m1[VW-1:0];
        es_nxt = from_m1[VW-1:0];
        et_nxt = to_m1[VW-1:0];
        if (start) begin
          if (in_item.req_type == REQ_FINISH) begin
            v_nxt = '0;  fin_nxt = '0;  cnt_nxt = '0;  pass_nxt = 1'b0;
          end else if (!edge_ok) begin
            drop_nxt = 1'b1;
          end
        end
      end
      S_EDGE_WR: begin
        ed_req.we = 1'b1;
        ed_req.waddr = etot_r[EW-1:0];
        ed_req.wdata = '{src: es_r, tgt: et_r, fnext: fh_rdata, rnext: rh_rdata};
        fh_req.we = 1'b1;  fh_req.waddr = es_r;  fh_req.wdata = {1'b0, etot_r[EW-1:0]};
        rh_req.we = 1'b1;  rh_req.waddr = et_r;  rh_req.wdata = {1'b0, etot_r[EW-1:0]};
        etot_nxt = etot_r + ETW'(1);
      end
      S_P1_RD: begin
        vis_req.raddr = v_r[VW-1:0];
        sweep_nxt = '0;
        pass_nxt = (v_r == n_eff);
      end
      S_P1_CHK: begin
        if (vis_rdata) begin
          v_nxt = v_r + CNTW'(1);
        end else begin
          vis_req.we = 1'b1;  vis_req.waddr = v_ext[VW-1:0];  vis_req.wdata = 1'b1;
          fh_req.raddr = v_ext[VW-1:0];
          topv_nxt = v_ext[VW-1:0];
          d_nxt = CNTW'(1);
        end
      end
      S_W_HEAD: tope_nxt = pass_r ? rh_rdata : fh_rdata;
      S_W_EDGE: begin
        ed_req.raddr = tope_r[EW-1:0];
        stk_req.raddr = d_m2[VW-1:0];
        if (tope_r[HW-1]) begin
          if (!pass_r && fin_r < NMAX) begin
            fin_req.we = 1'b1;  fin_req.waddr = fin_r[VW-1:0];  fin_req.wdata = topv_r;
            fin_nxt = fin_r + CNTW'(1);
          end
          d_nxt = d_m1;
          if (d_r == CNTW'(1)) begin
            if (pass_r) begin
              fin_nxt = fin_m1;
            end else begin
              v_nxt = v_r + CNTW'(1);
            end
          end
        end
      end
      S_W_POP: begin
        topv_nxt = stk_rdata.vtx;
        tope_nxt = stk_rdata.link;
      end
      S_W_ERD: begin
        vis_req.raddr = ew;
        w_nxt = ew;
        ok_nxt = ({1'b0, ew} < n_eff) && ({1'b0, eo} < n_eff);
        tope_nxt = pass_r ? ed_rdata.rnext : ed_rdata.fnext;
      end
      S_W_CHK: begin
        if (push_ok) begin
          vis_req.we = 1'b1;  vis_req.waddr = w_r;  vis_req.wdata = 1'b1;
          stk_req.we = 1'b1;  stk_req.waddr = d_m1[VW-1:0];
          stk_req.wdata = '{vtx: topv_r, link: tope_r};
          fh_req.raddr = w_r;
          rh_req.raddr = w_r;
          topv_nxt = w_r;
          d_nxt = d_r + CNTW'(1);
        end
      end
      S_VCLR: begin
        vis_req.we = 1'b1;  vis_req.waddr = sweep_r;  vis_req.wdata = 1'b0;
        sweep_nxt = sweep_r + VW'(1);
      end
      S_P2_RD: fin_req.raddr = fin_m1[VW-1:0];
      S_P2_VRD: begin
        vis_req.raddr = fin_rdata;
        w_nxt = fin_rdata;
      end
      S_P2_CHK: begin
        if (u_ok) begin
          cnt_nxt = cnt_r + CNTW'(1);
          vis_req.we = 1'b1;  vis_req.waddr = w_ext[VW-1:0];  vis_req.wdata = 1'b1;
          rh_req.raddr = w_r;
          topv_nxt = w_r;
          d_nxt = CNTW'(1);
        end else begin
          fin_nxt = fin_m1;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        out_item.strongly_connected = (cnt_r == CNTW'(1));
        out_item.component_count = cnt_r;
        out_item.edges_dropped = drop_r;
        sweep_nxt = '0;
        etot_nxt = '0;
        drop_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      sweep_r <= '0;
      etot_r  <= '0;
      drop_r  <= 1'b0;
      pass_r  <= 1'b0;
      d_r     <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      etot_r  <= etot_nxt;
      drop_r  <= drop_nxt;
      pass_r  <= pass_nxt;
      d_r     <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    es_r <= es_nxt;  et_r <= et_nxt;  v_r <= v_nxt;  fin_r <= fin_nxt;
    cnt_r <= cnt_nxt;  topv_r <= topv_nxt;  tope_r <= tope_nxt;
    w_r <= w_nxt;  ok_r <= ok_nxt;
  end
endmodule

/* rtl/strong_connectivity_check_unit.sv */
// Top level of the strong connectivity check (Kosaraju) unit.
// Depends on scc_pkg, scc_ctrl and scc_ram.
//
//  channel | ports                      | handshake
//  input   | start, busy, in_item       | taken when start & !busy
//  result  | out_valid, out_item        | one-cycle strobe, cannot be held off
//  config  | cfg_we, cfg_wdata          | vertex_count written when cfg_we
//
// An edge item reads both heads in the cycle it is taken, then holds busy for
// the next cycle to write the edge record and both heads; a dropped edge does
// not hold busy. A finish item walks the forward lists from each unvisited
// vertex in order to record the finish order, clears the visited marks, walks
// the reverse lists in reverse finish order to count components, gives the
// result and clears heads and marks, as it also does while busy after reset.
// Results are never stalled; the strobe lasts exactly one cycle.
module strong_connectivity_check_unit import scc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_item,
  output logic            out_valid,
  output out_item_t       out_item,
  input  logic            cfg_we,
  input  logic [CNTW-1:0] cfg_wdata
);
  logic [CNTW-1:0] vcount_r;

  head_req_t fh_req, rh_req;
  edge_req_t ed_req;
  vis_req_t  vis_req;
  fin_req_t  fin_req;
  stk_req_t  stk_req;
  logic [HW-1:0] fh_rdata, rh_rdata;
  edge_rec_t     ed_rdata;
  logic          vis_rdata;
  logic [VW-1:0] fin_rdata;
  stk_rec_t      stk_rdata;

  // hold the vertex count; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CNTW'(1);
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  scc_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .vcount(vcount_r),
    .fh_req, .fh_rdata, .rh_req, .rh_rdata, .ed_req, .ed_rdata,
    .vis_req, .vis_rdata, .fin_req, .fin_rdata, .stk_req, .stk_rdata
  );

  // forward and reverse list heads, one per vertex
  scc_ram #(.WIDTH(HW), .DEPTH(MAX_V)) u_fhead (
    .clk, .we(fh_req.we), .waddr(fh_req.waddr), .wdata(fh_req.wdata),
    .raddr(fh_req.raddr), .rdata(fh_rdata));
  scc_ram #(.WIDTH(HW), .DEPTH(MAX_V)) u_rhead (
    .clk, .we(rh_req.we), .waddr(rh_req.waddr), .wdata(rh_req.wdata),
    .raddr(rh_req.raddr), .rdata(rh_rdata));

  // edge store: endpoints and both next links in one record
  scc_ram #(.WIDTH($bits(edge_rec_t)), .DEPTH(MAX_E)) u_edges (
    .clk, .we(ed_req.we), .waddr(ed_req.waddr), .wdata(ed_req.wdata),
    .raddr(ed_req.raddr), .rdata(ed_rdata));

  scc_ram #(.WIDTH(1), .DEPTH(MAX_V)) u_visited (
    .clk, .we(vis_req.we), .waddr(vis_req.waddr), .wdata(vis_req.wdata),
    .raddr(vis_req.raddr), .rdata(vis_rdata));

  // finish order of the first pass
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_finish (
    .clk, .we(fin_req.we), .waddr(fin_req.waddr), .wdata(fin_req.wdata),
    .raddr(fin_req.raddr), .rdata(fin_rdata));

  // walk stack below the top entry, which lives in the controller
  scc_ram #(.WIDTH($bits(stk_rec_t)), .DEPTH(MAX_V)) u_stack (
    .clk, .we(stk_req.we), .waddr(stk_req.waddr), .wdata(stk_req.wdata),
    .raddr(stk_req.raddr), .rdata(stk_rdata));
endmodule

/* rtl/scc_checker.sv */
// Port-level checks for strong_connectivity_check_unit, bound to the top.
// Depends on scc_pkg.
module scc_checker import scc_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            busy,
  input logic            out_valid,
  input out_item_t       out_item
);
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.strongly_connected ==
                   (out_item.component_count == CNTW'(1))))
    else $error("flag disagrees with count");
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.component_count != '0))
    else $error("zero components");
endmodule

bind strong_connectivity_check_unit scc_checker u_scc_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_item(out_item)
);

/* bench/scc_checker.sv */
// Checker for the strong connectivity check unit: watches the item, result and
// vertex_count ports, predicts each result and compares the whole result item.
// Depends on scc_pkg.
module scc_tb_checker import scc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  in_item_t        in_item,
  input  logic            out_valid,
  input  out_item_t       out_item,
  input  logic            cfg_we,
  input  logic [CNTW-1:0] cfg_wdata,
  output int              error_count,
  output int              results_pending
);

  localparam int NO_EDGE = -1;

  int fwd_head [MAX_V];
  int rev_head [MAX_V];
  int edge_src [MAX_E];
  int edge_dst [MAX_E];
  int fwd_link [MAX_E];
  int rev_link [MAX_E];
  int stored_edges;
  bit seen [MAX_V];
  int finish_seq [MAX_V];
  int walk_vtx [MAX_V];
  int walk_edge [MAX_V];
  bit any_dropped;
  logic [CNTW-1:0] vertex_count;

  out_item_t scc_results [$];

  function int active_vertices();
    int n;
    n = vertex_count;
    if (n == 0) n = 1;
    if (n > MAX_V) n = MAX_V;
    return n;
  endfunction

  function void clear_graph();
    for (int i = 0; i < MAX_V; i++) begin
      fwd_head[i] = NO_EDGE;
      rev_head[i] = NO_EDGE;
      seen[i] = 1'b0;
    end
    stored_edges = 0;
    any_dropped = 1'b0;
  endfunction

  function void load_edge(int from, int to);
    int n;
    n = active_vertices();
    if (from == 0 || from > n || to == 0 || to > n || stored_edges >= MAX_E) begin
      any_dropped = 1'b1;
    end else begin
      edge_src[stored_edges] = from - 1;
      edge_dst[stored_edges] = to - 1;
      fwd_link[stored_edges] = fwd_head[from - 1];
      fwd_head[from - 1] = stored_edges;
      rev_link[stored_edges] = rev_head[to - 1];
      rev_head[to - 1] = stored_edges;
      stored_edges++;
    end
  endfunction

  // Iterative depth-first walk; returns the updated finish count.
  function int dfs_walk(int root, int n, bit on_reverse, bit record, int done);
    int depth, top, e, w, other;
    depth = 1;
    seen[root] = 1'b1;
    walk_vtx[0] = root;
    walk_edge[0] = on_reverse ? rev_head[root] : fwd_head[root];
    while (depth > 0) begin
      top = depth - 1;
      e = walk_edge[top];
      if (e == NO_EDGE) begin
        if (record && done < MAX_V) begin
          finish_seq[done] = walk_vtx[top];
          done++;
        end
        depth--;
      end else begin
        w = on_reverse ? edge_src[e] : edge_dst[e];
        other = on_reverse ? edge_dst[e] : edge_src[e];
        walk_edge[top] = on_reverse ? rev_link[e] : fwd_link[e];
        if (w < n && other < n && !seen[w] && depth < MAX_V) begin
          seen[w] = 1'b1;
          walk_vtx[depth] = w;
          walk_edge[depth] = on_reverse ? rev_head[w] : fwd_head[w];
          depth++;
        end
      end
    end
    return done;
  endfunction

  function out_item_t count_components();
    out_item_t r;
    int n, done, comps, u;
    n = active_vertices();
    done = 0;
    comps = 0;
    for (int v = 0; v < MAX_V; v++) seen[v] = 1'b0;
    for (int v = 0; v < n; v++)
      if (!seen[v]) done = dfs_walk(v, n, 1'b0, 1'b1, done);
    for (int v = 0; v < MAX_V; v++) seen[v] = 1'b0;
    for (int i = done; i > 0; i--) begin
      u = finish_seq[i - 1];
      if (u < n && !seen[u]) begin
        comps++;
        void'(dfs_walk(u, n, 1'b1, 1'b0, done));
      end
    end
    r.strongly_connected = (comps == 1);
    r.component_count = CNTW'(comps);
    r.edges_dropped = any_dropped;
    clear_graph();
    return r;
  endfunction

  initial begin
    error_count = 0;
    results_pending = 0;
    vertex_count = 1;
    clear_graph();
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      vertex_count = 1;
      clear_graph();
      scc_results.delete();
    end else begin
      if (cfg_we) vertex_count = cfg_wdata;
      if (start && !busy) begin
        if (in_item.req_type == REQ_FINISH)
          scc_results.insert(scc_results.size(), count_components());
        else load_edge(in_item.edge_from, in_item.edge_to);
      end
      if (out_valid) begin
        if (scc_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result %p", out_item);
        end else begin
          want = scc_results.pop_front();
          if (want !== out_item) begin
            error_count++;
            if (error_count <= 10)
              $display("result mismatch: expected %p, got %p", want, out_item);
          end
        end
      end
    end
    results_pending = scc_results.size();
  end

endmodule

/* bench/strong_connectivity_check_unit_tb.sv */
// Testbench top for the strong connectivity check unit: drives edge and finish
// items and vertex_count writes, and gives the verdict from scc_tb_checker.
// Depends on scc_pkg, scc_tb_checker and the unit itself.
module strong_connectivity_check_unit_tb import scc_pkg::*;;

  localparam int STALL_LIMIT = 300000;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  in_item_t        in_item;
  logic            out_valid;
  out_item_t       out_item;
  logic            cfg_we;
  logic [CNTW-1:0] cfg_wdata;
  int              error_count;
  int              results_pending;
  int              items_sent;
  int              quiet_cycles;

  strong_connectivity_check_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  scc_tb_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .error_count(error_count), .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: count cycles in which no item, result or register write moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item after a random gap and hold it until the unit takes it.
  // Start stays high across back-to-back items, so it never toggles in one step.
  task automatic send_item(logic kind, logic [CNTW-1:0] from, logic [CNTW-1:0] to);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_item.req_type = kind;
    in_item.edge_from = from;
    in_item.edge_to = to;
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic add_edge(int from, int to);
    send_item(REQ_EDGE, CNTW'(from), CNTW'(to));
  endtask

  task automatic finish_graph();
    send_item(REQ_FINISH, CNTW'($urandom), CNTW'($urandom));
  endtask

  // Write vertex_count once all results are in and a trailing edge write has
  // landed; the unit may still be busy clearing after the last result.
  task automatic set_vertex_count(int value);
    start = 1'b0;
    wait (results_pending == 0);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = CNTW'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int n, edges, shape;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    items_sent = 0;
    quiet_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty graph at reset count, then bad endpoints, self loops and
    // repeated edges on a small cycle.
    finish_graph();
    set_vertex_count(4);
    add_edge(1, 2); add_edge(2, 3); add_edge(3, 1); add_edge(3, 1);
    add_edge(4, 4); add_edge(0, 1); add_edge(1, 5); add_edge(2047, 2047);
    finish_graph();
    add_edge(1, 2); add_edge(2, 3); add_edge(3, 4); add_edge(4, 1);
    finish_graph();
    // Zero count acts as one vertex.
    set_vertex_count(0);
    add_edge(1, 1); add_edge(1, 2);
    finish_graph();
    // Count lowered after loading: edges above the new count are ignored.
    set_vertex_count(10);
    add_edge(1, 9); add_edge(9, 2); add_edge(2, 1);
    set_vertex_count(3);
    finish_graph();
    // Count above the maximum clamps to the largest vertex.
    set_vertex_count(2047);
    add_edge(1024, 1); add_edge(1, 1024); add_edge(1025, 1);
    finish_graph();
    // Long ring inside the full vertex range.
    set_vertex_count(1024);
    for (int i = 1; i < 200; i++) add_edge(i, i + 1);
    add_edge(200, 1);
    finish_graph();

    // Random graphs: mostly small, valid edges with some noise; each graph
    // gets its own vertex_count.
    while (items_sent < 800) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(0, 2047);
        1: n = $urandom_range(1, 2);
        default: n = $urandom_range(3, 12);
      endcase
      set_vertex_count(n);
      if (n == 0) n = 1;
      if (n > MAX_V) n = MAX_V;
      edges = $urandom_range(0, 3 * ((n < 12) ? n : 12));
      shape = $urandom_range(0, 2);
      // A ring gives the walks a strongly connected core to find.
      if (shape == 0)
        for (int v = 1; v <= n && v <= 16; v++) add_edge(v, (v == n || v == 16) ? 1 : v + 1);
      for (int i = 0; i < edges; i++) begin
        if ($urandom_range(0, 19) == 0) add_edge($urandom_range(0, 2047), $urandom_range(0, 2047));
        else add_edge($urandom_range(1, n), $urandom_range(1, n));
      end
      finish_graph();
    end

    start = 1'b0;
    wait (results_pending == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/scc_pkg.sv
rtl/scc_ram.sv
rtl/scc_ctrl.sv
rtl/strong_connectivity_check_unit.sv
rtl/scc_checker.sv
bench/scc_checker.sv
bench/strong_connectivity_check_unit_tb.sv
